// ===== rtl/llq_pkg.sv =====
// ============================================================================
// llq_pkg - linked list queue manager package
// Sizes, op and status codes, and the request/response words passed between
// the unit's register stages and its list engine.
// ============================================================================
package llq_pkg;

  localparam int NODES = 32;
  localparam int LISTS = 8;

  // field widths of the command and result words
  localparam int OP_W     = 3;
  localparam int LIST_W   = 3;
  localparam int NODE_W   = 5;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 6;

  // link pointers carry one extra code (NODES) meaning "none"
  localparam int PTR_W      = $clog2(NODES + 1);
  localparam int NODE_IDX_W = $clog2(NODES);
  localparam int LIST_IDX_W = (LISTS > 1) ? $clog2(LISTS) : 1;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [NODE_IDX_W-1:0] node_idx_t;
  typedef logic [LIST_IDX_W-1:0] list_idx_t;

  localparam ptr_t NONE_PTR = PTR_W'(NODES);
  localparam ptr_t MAX_CNT  = PTR_W'(NODES);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 3'd0,
    OP_PUSH     = 3'd1,
    OP_INSERT   = 3'd2,
    OP_POP      = 3'd3,
    OP_REMOVE   = 3'd4,
    OP_CONTAINS = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_LINKED  = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [LIST_W-1:0] list_id;
    logic [NODE_W-1:0] node_id;
    logic [NODE_W-1:0] position_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   popped_node;
    logic                found;
    logic [LEN_W-1:0]    list_length;
  } rsp_t;

  function automatic logic is_node(ptr_t p);
    return int'(p) < NODES;
  endfunction

endpackage

// ===== rtl/llq_engine.sv =====
// ============================================================================
// llq_engine - list table and link update
// Holds head/tail/count per list and prev/next/mark/owner per node. Decodes
// one registered command word and applies all its link writes at the next
// edge; the response word is combinational for the result register.
// ============================================================================
module llq_engine import llq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_vld_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  ptr_t      head_q [LISTS];
  ptr_t      tail_q [LISTS];
  ptr_t      cnt_q  [LISTS];
  ptr_t      next_q [NODES];
  ptr_t      prev_q [NODES];
  logic      mark_q [NODES];
  list_idx_t owner_q [NODES];

  list_idx_t lsel;
  logic      list_ok;
  node_idx_t n_idx, pos_idx;
  ptr_t      n_ptr, pos_ptr;
  logic      n_ok, n_in, pos_in;
  ptr_t      head, tail, cnt, cnt_up, cnt_dn, cnt_new;
  logic      t_ok, h_ok;
  ptr_t      ins_p, pop_nx, rem_p, rem_nx;
  logic      ins_p_ok, pop_nx_ok, rem_p_ok, rem_nx_ok;
  logic      do_clr, do_push, do_ins, do_pop, do_rem;
  logic [STATUS_W-1:0] status;

  assign lsel    = req_i.list_id[LIST_IDX_W-1:0];
  assign list_ok = int'(req_i.list_id) < LISTS;
  assign n_idx   = req_i.node_id[NODE_IDX_W-1:0];
  assign pos_idx = req_i.position_id[NODE_IDX_W-1:0];
  assign n_ptr   = PTR_W'(req_i.node_id);
  assign pos_ptr = PTR_W'(req_i.position_id);
  assign n_ok    = is_node(n_ptr);

  assign head = head_q[lsel];
  assign tail = tail_q[lsel];
  assign cnt  = cnt_q[lsel];
  assign t_ok = is_node(tail);
  assign h_ok = is_node(head);

  // membership from owner and mark, no list walk
  assign n_in   = n_ok && mark_q[n_idx] && (owner_q[n_idx] == lsel);
  assign pos_in = is_node(pos_ptr) && mark_q[pos_idx] && (owner_q[pos_idx] == lsel);

  assign ins_p     = prev_q[pos_idx];
  assign ins_p_ok  = is_node(ins_p);
  assign pop_nx    = next_q[head[NODE_IDX_W-1:0]];
  assign pop_nx_ok = is_node(pop_nx);
  assign rem_p_ok  = is_node(prev_q[n_idx]);
  assign rem_nx_ok = is_node(next_q[n_idx]);
  assign rem_p     = rem_p_ok  ? prev_q[n_idx] : NONE_PTR;
  assign rem_nx    = rem_nx_ok ? next_q[n_idx] : NONE_PTR;

  assign cnt_up = (cnt < MAX_CNT) ? cnt + PTR_W'(1) : cnt;
  assign cnt_dn = (cnt != '0) ? cnt - PTR_W'(1) : cnt;

  always_comb begin
    status  = ST_OK;
    do_clr  = 1'b0;
    do_push = 1'b0;
    do_ins  = 1'b0;
    do_pop  = 1'b0;
    do_rem  = 1'b0;
    case (req_i.op)
      OP_CLEAR: begin
        do_clr = 1'b1;
      end
      OP_PUSH: begin
        if (!n_ok)                status  = ST_MISSING;
        else if (mark_q[n_idx])   status  = ST_LINKED;
        else                      do_push = 1'b1;
      end
      OP_INSERT: begin
        // position check goes ahead of the linked check
        if (!n_ok || !pos_in)     status = ST_MISSING;
        else if (mark_q[n_idx])   status = ST_LINKED;
        else                      do_ins = 1'b1;
      end
      OP_POP: begin
        if (!h_ok) status = ST_EMPTY;
        else       do_pop = 1'b1;
      end
      OP_REMOVE: begin
        if (!n_in || cnt == '0) status = ST_MISSING;
        else                    do_rem = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_new = cnt;
    if (do_clr)                cnt_new = '0;
    else if (do_push || do_ins) cnt_new = cnt_up;
    else if (do_pop || do_rem)  cnt_new = cnt_dn;
  end

  always_comb begin
    rsp_o = '0;
    if (!list_ok) begin
      rsp_o.status = ST_MISSING;
    end else begin
      rsp_o.status      = status;
      rsp_o.popped_node = do_pop ? head[NODE_W-1:0] : '0;
      rsp_o.found       = do_pop || ((req_i.op == OP_CONTAINS) && n_in);
      rsp_o.list_length = LEN_W'(cnt_new);
    end
  end

  // write order mirrors the sequential update: later writes win on a clash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LISTS; i++) begin
        head_q[i] <= NONE_PTR;
        tail_q[i] <= NONE_PTR;
        cnt_q[i]  <= '0;
      end
      for (int i = 0; i < NODES; i++) begin
        next_q[i] <= NONE_PTR;
        prev_q[i] <= NONE_PTR;
        mark_q[i] <= 1'b0;
      end
    end else if (req_vld_i && list_ok) begin
      if (do_clr) begin
        head_q[lsel] <= NONE_PTR;
        tail_q[lsel] <= NONE_PTR;
      end
      if (do_push) begin
        prev_q[n_idx] <= t_ok ? tail : NONE_PTR;
        next_q[n_idx] <= NONE_PTR;
        if (t_ok) next_q[tail[NODE_IDX_W-1:0]] <= n_ptr;
        else      head_q[lsel] <= n_ptr;
        tail_q[lsel]  <= n_ptr;
        mark_q[n_idx] <= 1'b1;
      end
      if (do_ins) begin
        prev_q[n_idx] <= ins_p_ok ? ins_p : NONE_PTR;
        next_q[n_idx] <= pos_ptr;
        if (ins_p_ok) next_q[ins_p[NODE_IDX_W-1:0]] <= n_ptr;
        else          head_q[lsel] <= n_ptr;
        prev_q[pos_idx] <= n_ptr;
        mark_q[n_idx]   <= 1'b1;
      end
      if (do_pop) begin
        if (pop_nx_ok) begin
          head_q[lsel] <= pop_nx;
          prev_q[pop_nx[NODE_IDX_W-1:0]] <= NONE_PTR;
        end else begin
          head_q[lsel] <= NONE_PTR;
          tail_q[lsel] <= NONE_PTR;
        end
        prev_q[head[NODE_IDX_W-1:0]] <= NONE_PTR;
        next_q[head[NODE_IDX_W-1:0]] <= NONE_PTR;
        mark_q[head[NODE_IDX_W-1:0]] <= 1'b0;
      end
      if (do_rem) begin
        if (rem_p_ok) next_q[rem_p[NODE_IDX_W-1:0]] <= rem_nx;
        else          head_q[lsel] <= rem_nx;
        if (rem_nx_ok) prev_q[rem_nx[NODE_IDX_W-1:0]] <= rem_p;
        else           tail_q[lsel] <= rem_p;
        prev_q[n_idx] <= NONE_PTR;
        next_q[n_idx] <= NONE_PTR;
        mark_q[n_idx] <= 1'b0;
      end
      cnt_q[lsel] <= cnt_new;
    end
  end

  // owner has no reset; only read behind a set mark
  always_ff @(posedge clk_i) begin
    if (req_vld_i && list_ok && (do_push || do_ins)) begin
      owner_q[n_idx] <= lsel;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_vld_i |-> (cnt <= MAX_CNT))
    else $error("list count beyond pool size");

  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_vld_i && rsp_o.found && req_i.op == OP_POP) |-> (rsp_o.status == ST_OK))
    else $error("pop reported found with error status");

  a_err_no_mark_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_vld_i && rsp_o.status != ST_OK) |->
      !(do_push || do_ins || do_pop || do_rem))
    else $error("failed op changed a linked mark");

  a_push_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_vld_i && list_ok && do_push) |=> mark_q[$past(n_idx)])
    else $error("push did not mark the node");
`endif

endmodule

// ===== rtl/linked_list_queue_manager_unit.sv =====
// ============================================================================
// linked_list_queue_manager_unit - doubly linked list queue manager
// Command register, list engine and result register; one word per cycle.
// ============================================================================
// Path: a word taken into the command register passes the engine into the
//   result register; its result shows on the ports with done_o high for one cycle.
// Throughput: one word per cycle; busy stays low, each word's link update
//   finishes in the engine stage before the next word reaches it.
// Reset: rst_ni clears all lists and links at once; the receiver cannot stall.
module linked_list_queue_manager_unit import llq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     op_i,
  input  logic [LIST_W-1:0]   list_id_i,
  input  logic [NODE_W-1:0]   node_id_i,
  input  logic [NODE_W-1:0]   position_id_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [NODE_W-1:0]   popped_node_o,
  output logic                found_o,
  output logic [LEN_W-1:0]    list_length_o
);

  req_t req_q;
  logic req_vld_q;
  rsp_t rsp_d, rsp_q;
  logic done_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      req_vld_q <= start && !busy;
      done_q    <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q.op          <= op_i;
      req_q.list_id     <= list_id_i;
      req_q.node_id     <= node_id_i;
      req_q.position_id <= position_id_i;
    end
    if (req_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  llq_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_vld_i (req_vld_q),
    .req_i     (req_q),
    .rsp_o     (rsp_d)
  );

  assign done_o        = done_q;
  assign status_o      = rsp_q.status;
  assign popped_node_o = rsp_q.popped_node;
  assign found_o       = rsp_q.found;
  assign list_length_o = rsp_q.list_length;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - linked list queue manager unit testbench
// Drives list commands (clear, push, insert, pop, remove, contains, spare
// codes) through the start/busy handshake and checks every done_o word
// against a table-based model of the lists, nodes and links that the
// testbench keeps itself. Directed corner cases come first, then random
// traffic biased toward commands that succeed.
// ----------------------------------------------------------------------------
module tb_top import llq_pkg::*; ();

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RAND_WORDS = 170;  // per gap setting

  // list table, node links and the queue of result words still owed
  class llq_scoreboard;
    ptr_t               head_ptr_q[LISTS];
    ptr_t               tail_ptr_q[LISTS];
    logic [LEN_W-1:0]   length_q[LISTS];
    ptr_t               next_q[NODES];
    ptr_t               prev_q[NODES];
    bit                 linked[NODES];
    list_idx_t          owner[NODES];
    rsp_t               owed_rsp[$];
    int                 errors;

    function new();
      for (int i = 0; i < LISTS; i++) begin
        head_ptr_q[i] = NONE_PTR;
        tail_ptr_q[i] = NONE_PTR;
        length_q[i]   = '0;
      end
      for (int i = 0; i < NODES; i++) begin
        next_q[i] = NONE_PTR;
        prev_q[i] = NONE_PTR;
        linked[i] = 1'b0;
        owner[i]  = '0;
      end
      errors = 0;
    endfunction

    function bit holds(ptr_t n, list_idx_t l);
      return (n < NODES) && linked[n[NODE_IDX_W-1:0]] &&
             (owner[n[NODE_IDX_W-1:0]] == l);
    endfunction

    function void grow(list_idx_t l);
      if (length_q[l] < NODES) length_q[l]++;
    endfunction

    function void shrink(list_idx_t l);
      if (length_q[l] > 0) length_q[l]--;
    endfunction

    // apply one accepted command word and queue the result it owes
    function void note_command(logic [OP_W-1:0] op, list_idx_t l,
                               logic [NODE_W-1:0] n, logic [NODE_W-1:0] p);
      rsp_t r;
      ptr_t t, pv, nx, h;
      r = '0;
      case (op)
        OP_CLEAR: begin
          head_ptr_q[l] = NONE_PTR;
          tail_ptr_q[l] = NONE_PTR;
          length_q[l]   = '0;
        end
        OP_PUSH: begin
          if (linked[n]) begin
            r.status = ST_LINKED;
          end else begin
            t = tail_ptr_q[l];
            prev_q[n] = (t < NODES) ? t : NONE_PTR;
            next_q[n] = NONE_PTR;
            if (t < NODES) next_q[t[NODE_IDX_W-1:0]] = PTR_W'(n);
            else head_ptr_q[l] = PTR_W'(n);
            tail_ptr_q[l] = PTR_W'(n);
            linked[n] = 1'b1;
            owner[n] = l;
            grow(l);
          end
        end
        OP_INSERT: begin
          // position is checked before the node's own mark
          if (!holds(PTR_W'(p), l)) begin
            r.status = ST_MISSING;
          end else if (linked[n]) begin
            r.status = ST_LINKED;
          end else begin
            pv = prev_q[p];
            prev_q[n] = (pv < NODES) ? pv : NONE_PTR;
            next_q[n] = PTR_W'(p);
            if (pv < NODES) next_q[pv[NODE_IDX_W-1:0]] = PTR_W'(n);
            else head_ptr_q[l] = PTR_W'(n);
            prev_q[p] = PTR_W'(n);
            linked[n] = 1'b1;
            owner[n] = l;
            grow(l);
          end
        end
        OP_POP: begin
          h = head_ptr_q[l];
          if (h >= NODES) begin
            r.status = ST_EMPTY;
          end else begin
            nx = next_q[h[NODE_IDX_W-1:0]];
            if (nx < NODES) begin
              head_ptr_q[l] = nx;
              prev_q[nx[NODE_IDX_W-1:0]] = NONE_PTR;
            end else begin
              head_ptr_q[l] = NONE_PTR;
              tail_ptr_q[l] = NONE_PTR;
            end
            prev_q[h[NODE_IDX_W-1:0]] = NONE_PTR;
            next_q[h[NODE_IDX_W-1:0]] = NONE_PTR;
            linked[h[NODE_IDX_W-1:0]] = 1'b0;
            shrink(l);
            r.popped_node = h[NODE_W-1:0];
            r.found = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (!holds(PTR_W'(n), l) || length_q[l] == 0) begin
            r.status = ST_MISSING;
          end else begin
            pv = prev_q[n];
            nx = next_q[n];
            if (pv >= NODES) pv = NONE_PTR;
            if (nx >= NODES) nx = NONE_PTR;
            if (pv != NONE_PTR) next_q[pv[NODE_IDX_W-1:0]] = nx;
            else head_ptr_q[l] = nx;
            if (nx != NONE_PTR) prev_q[nx[NODE_IDX_W-1:0]] = pv;
            else tail_ptr_q[l] = pv;
            prev_q[n] = NONE_PTR;
            next_q[n] = NONE_PTR;
            linked[n] = 1'b0;
            shrink(l);
          end
        end
        OP_CONTAINS: r.found = holds(PTR_W'(n), l);
        default: ;
      endcase
      r.list_length = length_q[l];
      owed_rsp.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (owed_rsp.size() == 0) begin
        report_mismatch("result word with nothing pending");
        return;
      end
      want = owed_rsp.pop_front();
      if (got.status != want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.popped_node != want.popped_node)
        report_mismatch($sformatf("popped_node got %0d want %0d",
                                  got.popped_node, want.popped_node));
      if (got.found != want.found)
        report_mismatch($sformatf("found got %0d want %0d", got.found, want.found));
      if (got.list_length != want.list_length)
        report_mismatch($sformatf("list_length got %0d want %0d",
                                  got.list_length, want.list_length));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0]     op_i = '0;
  logic [LIST_W-1:0]   list_id_i = '0;
  logic [NODE_W-1:0]   node_id_i = '0;
  logic [NODE_W-1:0]   position_id_i = '0;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [NODE_W-1:0]   popped_node_o;
  logic                found_o;
  logic [LEN_W-1:0]    list_length_o;

  llq_scoreboard sb = new();
  int gap_pct = 0;
  int cycles = 0;

  linked_list_queue_manager_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .list_id_i     (list_id_i),
    .node_id_i     (node_id_i),
    .position_id_i (position_id_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .popped_node_o (popped_node_o),
    .found_o       (found_o),
    .list_length_o (list_length_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result({status_o, popped_node_o, found_o, list_length_o});
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[linked_list_queue_manager_unit] ERROR");
      $finish;
    end
  end

  // one command word; start stays high across back-to-back words
  task automatic send_cmd(logic [OP_W-1:0] op, list_idx_t l,
                          logic [NODE_W-1:0] n, logic [NODE_W-1:0] p);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    op_i          <= op;
    list_id_i     <= l;
    node_id_i     <= n;
    position_id_i <= p;
    do @(posedge clk_i); while (busy);
    sb.note_command(op, l, n, p);
  endtask

  function automatic logic [NODE_W-1:0] pick_free();
    int cand[$];
    for (int i = 0; i < NODES; i++)
      if (!sb.linked[i]) cand.push_back(i);
    if (cand.size() == 0) return NODE_W'($urandom_range(NODES - 1));
    return NODE_W'(cand[$urandom_range(cand.size() - 1)]);
  endfunction

  // includes nodes left marked by a clear of their list
  function automatic logic [NODE_W-1:0] pick_member(list_idx_t l);
    int cand[$];
    for (int i = 0; i < NODES; i++)
      if (sb.holds(PTR_W'(i), l)) cand.push_back(i);
    if (cand.size() == 0) return NODE_W'($urandom_range(NODES - 1));
    return NODE_W'(cand[$urandom_range(cand.size() - 1)]);
  endfunction

  task automatic rand_cmd();
    logic [OP_W-1:0] op;
    list_idx_t l;
    logic [NODE_W-1:0] n, p;
    int sel;
    // half the traffic on two lists so they grow long
    l = LIST_IDX_W'($urandom_range(1) ? $urandom_range(1) : $urandom_range(LISTS - 1));
    n = NODE_W'($urandom_range(NODES - 1));
    p = NODE_W'($urandom_range(NODES - 1));
    sel = $urandom_range(99);
    if (sel < 3) begin
      op = OP_CLEAR;
    end else if (sel < 33) begin
      op = OP_PUSH;
      if ($urandom_range(99) < 80) n = pick_free();
    end else if (sel < 53) begin
      op = OP_INSERT;
      if ($urandom_range(99) < 85) p = pick_member(l);
      if ($urandom_range(99) < 80) n = pick_free();
    end else if (sel < 68) begin
      op = OP_POP;
    end else if (sel < 83) begin
      op = OP_REMOVE;
      if ($urandom_range(99) < 80) n = pick_member(l);
    end else if (sel < 95) begin
      op = OP_CONTAINS;
      if ($urandom_range(1)) n = pick_member(l);
    end else begin
      op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
    end
    send_cmd(op, l, n, p);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_cmd(OP_POP,      7, 0,  0);   // pop on empty list
    send_cmd(OP_CONTAINS, 7, 31, 0);
    send_cmd(OP_REMOVE,   0, 0,  0);   // remove from empty list
    send_cmd(OP_INSERT,   0, 1,  0);   // position not linked
    send_cmd(OP_PUSH,     0, 0,  31);
    send_cmd(OP_PUSH,     0, 31, 0);
    send_cmd(OP_PUSH,     7, 5,  0);
    send_cmd(OP_PUSH,     3, 0,  0);   // already linked elsewhere
    send_cmd(OP_INSERT,   0, 0,  31);  // node already linked
    send_cmd(OP_INSERT,   0, 0,  5);   // position in other list wins
    send_cmd(OP_INSERT,   0, 10, 0);   // new head
    send_cmd(OP_INSERT,   0, 11, 31);  // middle
    send_cmd(OP_CONTAINS, 0, 31, 0);
    send_cmd(OP_CONTAINS, 1, 31, 0);
    send_cmd(OP_REMOVE,   0, 11, 0);
    send_cmd(OP_REMOVE,   0, 10, 0);
    send_cmd(OP_SPARE_A,  0, 31, 31);
    send_cmd(OP_SPARE_B,  0, 0,  0);
    send_cmd(OP_CLEAR,    0, 0,  0);   // nodes 0 and 31 stay marked
    send_cmd(OP_CONTAINS, 0, 0,  0);
    send_cmd(OP_PUSH,     1, 0,  0);
    send_cmd(OP_REMOVE,   0, 0,  0);   // stale node, count zero
    send_cmd(OP_PUSH,     0, 20, 0);
    send_cmd(OP_REMOVE,   0, 31, 0);   // stale node unlinked via old links
    send_cmd(OP_POP,      7, 0,  0);

    gap_pct = 10;
    repeat (RAND_WORDS) rand_cmd();
    gap_pct = 83;
    repeat (RAND_WORDS) rand_cmd();
    gap_pct = 0;
    repeat (RAND_WORDS) rand_cmd();
    start <= 1'b0;

    while (sb.owed_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("[linked_list_queue_manager_unit] OK");
    else
      $display("[linked_list_queue_manager_unit] ERROR");
    $finish;
  end

endmodule

// ===== linked_list_queue_manager_unit.f =====
rtl/llq_pkg.sv
rtl/llq_engine.sv
rtl/linked_list_queue_manager_unit.sv
tb/tb_top.sv
